// File: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and codes of the sync token tracker: transfer payloads,
// command, result kind, error and phase codes, and the slot record that
// moves around the ring of cells.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_QUERY    = 3'd2;
    localparam logic [2:0] CMD_TICK     = 3'd3;
    localparam logic [2:0] CMD_ACK      = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_SENT   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] SYNC_UNKNOWN = 2'd0;
    localparam logic [1:0] SYNC_ACKED   = 2'd1;
    localparam logic [1:0] SYNC_PENDING = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_DUPLICATE = 3'd1;
    localparam logic [2:0] ERR_FULL      = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
    localparam logic [2:0] ERR_PHASE     = 3'd4;
    localparam logic [2:0] ERR_DIRECTION = 3'd5;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_SENT  = 2'd1,
        PH_ACKED = 2'd2
    } t_phase;

    typedef struct packed {
        logic   valid;
        t_phase phase;
    } t_slot;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] identifier;
        logic [4:0]  send_room;
        logic        toward_core;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] token_id;
        logic [1:0]  sync_state;
        logic [2:0]  error_code;
        logic [3:0]  src_device;
        logic        last;
    } t_out;

endpackage

// File: sv/sync_token_tracker.sv
// ----------------------------------------------------------------------------
// sync_token_tracker
// Table of synchronization tokens held in a ring of cells. Register, remove,
// query, tick and ack toward the core each rotate the ring past a sequencer
// that edits the record at the head.
//
//   channel   direction  signals                               payload
//   in        input      i_in_valid / o_in_stall               t_in
//   out       output     o_out_valid / i_out_stall             t_out
//   config    input      psel penable pwrite paddr pwdata ...  source_device
//
// A command is taken, then the ring turns once, then the final result is
// loaded into the output register. A register that finds a free slot turns
// the ring twice. An ack toward the device goes straight to the final
// result; an undefined command is taken without one.
// A tick pauses the ring while a sent signal waits on a stalled output,
// and the final result waits likewise. Reset empties the table at once;
// source_device resets to 0.
// ----------------------------------------------------------------------------
module sync_token_tracker #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  stt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output stt_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import stt_pkg::*;

    localparam int TW = (ID_BITS < 16) ? ID_BITS : 16;

    logic [3:0]    r_src_dev;
    logic          shift;
    t_slot         wb;
    logic [TW-1:0] wb_tok;
    t_slot         slot_d [TABLE_DEPTH];
    t_slot         slot_q [TABLE_DEPTH];
    logic [TW-1:0] tok_d  [TABLE_DEPTH];
    logic [TW-1:0] tok_q  [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_dev <= 4'd0;
        end else if (psel && penable && pwrite && paddr <= 2'd3) begin
            r_src_dev <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {28'd0, r_src_dev};

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
        if (i == TABLE_DEPTH - 1) begin : g_tail
            assign slot_d[i] = wb;
            assign tok_d[i]  = wb_tok;
        end else begin : g_link
            assign slot_d[i] = slot_q[i+1];
            assign tok_d[i]  = tok_q[i+1];
        end
        stt_cell #(
            .TW (TW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_slot  (slot_d[i]),
            .i_tok   (tok_d[i]),
            .o_slot  (slot_q[i]),
            .o_tok   (tok_q[i])
        );
    end

    stt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TW          (TW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_dev   (r_src_dev),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_head      (slot_q[0]),
        .i_head_tok  (tok_q[0]),
        .o_shift     (shift),
        .o_wb        (wb),
        .o_wb_tok    (wb_tok)
    );

endmodule

// File: sv/stt_cell.sv
// ----------------------------------------------------------------------------
// stt_cell
// One slot of the token table. On every shift the cell takes the record of
// its right neighbor (the tail cell takes the record written back from the
// head), so the whole table rotates past the head of the ring.
module stt_cell #(
    parameter int TW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  stt_pkg::t_slot i_slot,
    input  logic [TW-1:0]  i_tok,
    output stt_pkg::t_slot o_slot,
    output logic [TW-1:0]  o_tok
);
    import stt_pkg::*;

    logic          r_valid;
    t_phase        r_phase;
    logic [TW-1:0] r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_phase <= i_slot.phase;
            r_tok   <= i_tok;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.phase = r_phase;
    assign o_tok        = r_tok;

endmodule

// File: sv/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer of the tracker. Takes one command, rotates the ring of cells
// once past the head (twice for a register that finds room, never for an
// ack toward the device or an undefined command), edits the record at the
// head on its way back into the tail, and drives the result register.
// ----------------------------------------------------------------------------
module stt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int TW          = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [3:0]     i_src_dev,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  stt_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output stt_pkg::t_out  o_out_data,
    input  stt_pkg::t_slot i_head,
    input  logic [TW-1:0]  i_head_tok,
    output logic           o_shift,
    output stt_pkg::t_slot o_wb,
    output logic [TW-1:0]  o_wb_tok
);
    import stt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } t_state;

    t_state        r_state;
    logic [2:0]    r_cmd;
    logic [TW-1:0] r_id;
    logic [4:0]    r_room;
    logic          r_toward;
    logic [IW-1:0] r_pos;
    logic          r_dup;
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic          r_found;
    logic          r_acked;
    logic          r_badph;
    logic          r_out_vld;
    t_out          r_out;

    logic hit;
    logic is_send;
    logic can_emit;
    logic last_pos;
    logic load_out;
    t_out sent;
    t_out fin;

    assign hit      = i_head.valid && (i_head_tok == r_id);
    assign is_send  = (r_cmd == CMD_TICK) && i_head.valid && (i_head.phase == PH_WAIT)
                      && (r_room != 5'd0);
    assign can_emit = !r_out_vld || !i_out_stall;
    assign last_pos = (r_pos == IW'(TABLE_DEPTH - 1));
    assign load_out = ((r_state == ST_SCAN) && is_send && can_emit)
                      || ((r_state == ST_EMIT) && can_emit);

    assign o_shift = ((r_state == ST_SCAN) && (!is_send || can_emit)) || (r_state == ST_WRITE);

    always_comb begin
        o_wb     = i_head;
        o_wb_tok = i_head_tok;
        if (r_state == ST_SCAN) begin
            if (r_cmd == CMD_REMOVE && hit) begin
                o_wb.valid = 1'b0;
            end
            if (r_cmd == CMD_ACK && hit && i_head.phase == PH_SENT) begin
                o_wb.phase = PH_ACKED;
            end
            if (is_send) begin
                o_wb.phase = PH_SENT;
            end
        end else if (r_state == ST_WRITE && r_pos == r_free_idx) begin
            o_wb.valid = 1'b1;
            o_wb.phase = PH_WAIT;
            o_wb_tok   = r_id;
        end
    end

    always_comb begin
        sent            = '0;
        sent.kind       = KIND_SENT;
        sent.token_id   = 16'(i_head_tok);
        sent.src_device = i_src_dev;
    end

    always_comb begin
        fin            = '0;
        fin.token_id   = 16'(r_id);
        fin.last       = 1'b1;
        fin.kind       = KIND_DONE;
        case (r_cmd)
            CMD_REGISTER: begin
                if (r_dup) begin
                    fin.kind       = KIND_ERROR;
                    fin.error_code = ERR_DUPLICATE;
                end else if (!r_free) begin
                    fin.kind       = KIND_ERROR;
                    fin.error_code = ERR_FULL;
                end
            end
            CMD_QUERY: begin
                fin.kind = KIND_STATUS;
                if (r_found) begin
                    fin.sync_state = r_acked ? SYNC_ACKED : SYNC_PENDING;
                end
            end
            CMD_TICK: begin
                fin.token_id = 16'd0;
            end
            CMD_ACK: begin
                if (!r_toward) begin
                    fin.kind       = KIND_ERROR;
                    fin.error_code = ERR_DIRECTION;
                end else if (!r_found) begin
                    fin.kind       = KIND_ERROR;
                    fin.error_code = ERR_UNKNOWN;
                end else if (r_badph) begin
                    fin.kind       = KIND_ERROR;
                    fin.error_code = ERR_PHASE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd      <= i_in_data.cmd;
                        r_id       <= TW'(i_in_data.identifier);
                        r_room     <= i_in_data.send_room;
                        r_toward   <= i_in_data.toward_core;
                        r_pos      <= '0;
                        r_dup      <= 1'b0;
                        r_free     <= 1'b0;
                        r_free_idx <= '0;
                        r_found    <= 1'b0;
                        r_acked    <= 1'b0;
                        r_badph    <= 1'b0;
                        if (i_in_data.cmd == CMD_ACK && !i_in_data.toward_core) begin
                            r_state <= ST_EMIT;
                        end else if (i_in_data.cmd <= CMD_ACK) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (o_shift) begin
                        r_pos <= last_pos ? '0 : r_pos + IW'(1);
                        if (hit) begin
                            r_dup   <= 1'b1;
                            r_found <= 1'b1;
                            r_acked <= (i_head.phase == PH_ACKED);
                            r_badph <= (i_head.phase != PH_SENT);
                        end
                        if (!i_head.valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_pos;
                        end
                        if (is_send) begin
                            r_room <= r_room - 5'd1;
                            r_out  <= sent;
                        end
                        if (last_pos) begin
                            if (r_cmd == CMD_REGISTER && !r_dup && !hit
                                && (r_free || !i_head.valid)) begin
                                r_state <= ST_WRITE;
                            end else begin
                                r_state <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_WRITE: begin
                    r_pos <= last_pos ? '0 : r_pos + IW'(1);
                    if (last_pos) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (can_emit) begin
                        r_out   <= fin;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
